FILE: src/code_page_invalidation_tracker_macros.svh
// Assertion macros used by the checker file.
// Needs signals named clk and rst_n in the scope of use.
`ifndef CODE_PAGE_INVALIDATION_TRACKER_MACROS_SVH
`define CODE_PAGE_INVALIDATION_TRACKER_MACROS_SVH

// same-cycle implication
`define CPIT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpit assertion failed");

// next-cycle implication
`define CPIT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpit assertion failed");

`endif

FILE: src/cpit_pkg.sv
// Package of the code page invalidation tracker: sizes, codes, types.
// No dependencies.
package cpit_pkg;

    localparam int PAGE_COUNT     = 4096;
    localparam int PAGE_BYTES     = 4096;
    localparam int SLOTS_PER_PAGE = 8;
    localparam int BLOCK_COUNT    = 1024;

    localparam int PAGE_BITS   = $clog2(PAGE_COUNT);
    localparam int OFFSET_BITS = $clog2(PAGE_BYTES);
    localparam int RAM_BITS    = PAGE_BITS + OFFSET_BITS;
    localparam int BLOCK_BITS  = $clog2(BLOCK_COUNT);
    localparam int SLOT_BITS   = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
    localparam int CNT_BITS    = $clog2(SLOTS_PER_PAGE + 1);
    localparam int ADDR_BITS   = 32;
    localparam int ID_BITS     = 10;

    localparam int REGION_LSB  = 26;
    localparam logic [2:0] REGION_RAM = 3'd3;
    localparam logic [7:0] LIMIT_RESET = 8'd20;
    localparam logic [7:0] COUNT_MAX   = 8'd255;

    // command codes
    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [1:0] CMD_WRITE      = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UB_RD,
        ST_UB_CHK,
        ST_UP_RD,
        ST_UP_WR,
        ST_UB_DONE,
        ST_RG_RD,
        ST_RG_WR,
        ST_RG_DONE,
        ST_WF_RD,
        ST_WF_CHK,
        ST_WF_NEXT,
        ST_WF_FIN,
        ST_EMIT
    } state_t;

    typedef logic [SLOTS_PER_PAGE-1:0][BLOCK_BITS-1:0] slot_blocks_t;

    typedef struct packed {
        logic                      manual;
        logic [7:0]                count;
        logic [SLOTS_PER_PAGE-1:0] valid;
    } page_word_t;

    typedef struct packed {
        logic                 registered;
        logic [PAGE_BITS-1:0] first_page;
        logic [PAGE_BITS-1:0] last_page;
        logic                 in_ram;
    } block_word_t;

    typedef struct packed {
        logic                 match_hit;
        logic [SLOT_BITS-1:0] match_idx;
        logic                 free_hit;
        logic [SLOT_BITS-1:0] free_idx;
    } slot_scan_t;

endpackage

FILE: src/cpit_if.sv
// Channel interfaces: command transactions in, result transactions out.
// Depends on nothing but plain widths.
interface cpit_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [9:0]  block_id;
    logic [31:0] start_address;
    logic [31:0] end_address;
    logic [31:0] write_offset;

    modport source (output valid, cmd, block_id, start_address, end_address, write_offset,
                    input ready);
    modport sink   (input valid, cmd, block_id, start_address, end_address, write_offset,
                    output ready);
endinterface

interface cpit_res_if;
    logic       valid;
    logic       ready;
    logic       manual_protect;
    logic       write_hit;
    logic       suspended_valid;
    logic [9:0] suspended_block;
    logic       page_now_manual;
    logic       overflow;
    logic       last;

    modport source (output valid, manual_protect, write_hit, suspended_valid,
                    suspended_block, page_now_manual, overflow, last,
                    input ready);
    modport sink   (input valid, manual_protect, write_hit, suspended_valid,
                    suspended_block, page_now_manual, overflow, last,
                    output ready);
endinterface

FILE: src/cpit_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/cpit_slot_unit.sv
// Shared slot scan unit: finds a block's slot and the first free slot of a page.
// Depends on cpit_pkg.
module cpit_slot_unit (
    input  logic [cpit_pkg::SLOTS_PER_PAGE-1:0] valid,
    input  cpit_pkg::slot_blocks_t              blocks,
    input  logic [cpit_pkg::BLOCK_BITS-1:0]     id,
    output cpit_pkg::slot_scan_t                scan
);

    // lowest matching slot and lowest free slot
    always_comb
    begin
        scan = '0;
        for (int s = cpit_pkg::SLOTS_PER_PAGE - 1; s >= 0; s--)
        begin
            if (valid[s] && blocks[s] == id)
            begin
                scan.match_hit = 1'b1;
                scan.match_idx = cpit_pkg::SLOT_BITS'(s);
            end
            if (!valid[s])
            begin
                scan.free_hit = 1'b1;
                scan.free_idx = cpit_pkg::SLOT_BITS'(s);
            end
        end
    end

endmodule

FILE: src/cpit_seq.sv
// Sequencer of the tracker: page/block memories, page walks, result emission.
// Depends on cpit_pkg, cpit_if, cpit_ram, cpit_slot_unit.
module cpit_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        limit,
    cpit_cmd_if.sink          command,
    cpit_res_if.source        result
);

    cpit_pkg::state_t state_reg, state_next;

    logic [cpit_pkg::PAGE_BITS-1:0]  clr_reg, clr_next;
    logic [1:0]                      cmd_reg, cmd_next;
    logic [cpit_pkg::BLOCK_BITS-1:0] bid_reg, bid_next;
    logic [cpit_pkg::PAGE_BITS-1:0]  first_reg, first_next;
    logic [cpit_pkg::PAGE_BITS-1:0]  last_reg, last_next;
    logic                            ram_reg, ram_next;
    logic [cpit_pkg::BLOCK_BITS-1:0] ub_id_reg, ub_id_next;
    logic [cpit_pkg::PAGE_BITS-1:0]  ub_last_reg, ub_last_next;
    logic                            ub_was_reg, ub_was_next;
    logic [cpit_pkg::PAGE_BITS-1:0]  page_reg, page_next;
    logic [cpit_pkg::PAGE_BITS-1:0]  wf_page_reg, wf_page_next;
    logic                            wf_man_reg, wf_man_next;
    logic [7:0]                      wf_cnt_reg, wf_cnt_next;
    cpit_pkg::slot_blocks_t          list_reg, list_next;
    logic [cpit_pkg::CNT_BITS-1:0]   n_reg, n_next;
    logic [cpit_pkg::CNT_BITS-1:0]   k_reg, k_next;
    logic mp_reg, mp_next, ov_reg, ov_next, hit_reg, hit_next;
    logic pm_reg, pm_next, sv_reg, sv_next;

    // memory ports
    logic                            pg_we;
    logic [cpit_pkg::PAGE_BITS-1:0]  pg_waddr, pg_raddr;
    cpit_pkg::page_word_t            pg_wdata, pg_rdata;
    logic                            sl_we;
    cpit_pkg::slot_blocks_t          sl_wdata, sl_rdata;
    logic                            bk_we;
    logic [cpit_pkg::BLOCK_BITS-1:0] bk_waddr, bk_raddr;
    cpit_pkg::block_word_t           bk_wdata, bk_rdata;

    cpit_pkg::slot_scan_t            scan;
    cpit_pkg::slot_blocks_t          compact;
    logic [cpit_pkg::CNT_BITS-1:0]   compact_n;
    logic [7:0]                      cnt_inc;
    logic                            man_new;
    logic                            in_fire, out_fire, out_last;
    logic                            wr_in_ram;

    assign in_fire   = command.valid && command.ready;
    assign out_fire  = result.valid && result.ready;
    assign out_last  = !sv_reg || (k_reg == n_reg - cpit_pkg::CNT_BITS'(1));
    assign wr_in_ram = (command.write_offset[31:cpit_pkg::RAM_BITS] == '0);
    assign cnt_inc   = (wf_cnt_reg == cpit_pkg::COUNT_MAX) ? wf_cnt_reg : wf_cnt_reg + 8'd1;
    assign man_new   = wf_man_reg || (cnt_inc > limit);

    cpit_ram #(.WIDTH($bits(cpit_pkg::page_word_t)), .DEPTH(cpit_pkg::PAGE_COUNT)) u_page_ram (
        .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
        .raddr(pg_raddr), .rdata(pg_rdata)
    );

    cpit_ram #(.WIDTH($bits(cpit_pkg::slot_blocks_t)), .DEPTH(cpit_pkg::PAGE_COUNT)) u_slot_ram (
        .clk(clk), .we(sl_we), .waddr(pg_waddr), .wdata(sl_wdata),
        .raddr(pg_raddr), .rdata(sl_rdata)
    );

    cpit_ram #(.WIDTH($bits(cpit_pkg::block_word_t)), .DEPTH(cpit_pkg::BLOCK_COUNT)) u_block_ram (
        .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
        .raddr(bk_raddr), .rdata(bk_rdata)
    );

    cpit_slot_unit u_scan (
        .valid(pg_rdata.valid), .blocks(sl_rdata), .id(ub_id_reg), .scan(scan)
    );

    // pack the valid slots of the written page in slot order
    always_comb
    begin
        logic [cpit_pkg::CNT_BITS-1:0] pos;
        pos     = '0;
        compact = '0;
        for (int s = 0; s < cpit_pkg::SLOTS_PER_PAGE; s++)
        begin
            if (pg_rdata.valid[s])
            begin
                compact[pos[cpit_pkg::SLOT_BITS-1:0]] = sl_rdata[s];
                pos = pos + cpit_pkg::CNT_BITS'(1);
            end
        end
        compact_n = pos;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cpit_pkg::ST_CLEAR:
                if (clr_reg == cpit_pkg::PAGE_BITS'(cpit_pkg::PAGE_COUNT - 1))
                    state_next = cpit_pkg::ST_IDLE;
            cpit_pkg::ST_IDLE:
                if (in_fire)
                begin
                    case (command.cmd)
                        cpit_pkg::CMD_REGISTER,
                        cpit_pkg::CMD_UNREGISTER: state_next = cpit_pkg::ST_UB_RD;
                        cpit_pkg::CMD_WRITE:
                            state_next = wr_in_ram ? cpit_pkg::ST_WF_RD : cpit_pkg::ST_EMIT;
                        default:                  state_next = cpit_pkg::ST_EMIT;
                    endcase
                end
            cpit_pkg::ST_UB_RD:   state_next = cpit_pkg::ST_UB_CHK;
            cpit_pkg::ST_UB_CHK:
                state_next = (bk_rdata.registered && bk_rdata.in_ram &&
                              bk_rdata.first_page <= bk_rdata.last_page)
                             ? cpit_pkg::ST_UP_RD : cpit_pkg::ST_UB_DONE;
            cpit_pkg::ST_UP_RD:   state_next = cpit_pkg::ST_UP_WR;
            cpit_pkg::ST_UP_WR:
                state_next = (page_reg == ub_last_reg) ? cpit_pkg::ST_UB_DONE
                                                       : cpit_pkg::ST_UP_RD;
            cpit_pkg::ST_UB_DONE:
            begin
                case (cmd_reg)
                    cpit_pkg::CMD_REGISTER:
                        state_next = (first_reg <= last_reg) ? cpit_pkg::ST_RG_RD
                                                             : cpit_pkg::ST_RG_DONE;
                    cpit_pkg::CMD_UNREGISTER: state_next = cpit_pkg::ST_EMIT;
                    default:                  state_next = cpit_pkg::ST_WF_NEXT;
                endcase
            end
            cpit_pkg::ST_RG_RD:   state_next = cpit_pkg::ST_RG_WR;
            cpit_pkg::ST_RG_WR:
                state_next = (page_reg == last_reg) ? cpit_pkg::ST_RG_DONE
                                                    : cpit_pkg::ST_RG_RD;
            cpit_pkg::ST_RG_DONE: state_next = cpit_pkg::ST_EMIT;
            cpit_pkg::ST_WF_RD:   state_next = cpit_pkg::ST_WF_CHK;
            cpit_pkg::ST_WF_CHK:
                state_next = (pg_rdata.valid == '0) ? cpit_pkg::ST_EMIT
                                                    : cpit_pkg::ST_WF_NEXT;
            cpit_pkg::ST_WF_NEXT:
                state_next = (k_reg < n_reg) ? cpit_pkg::ST_UB_RD : cpit_pkg::ST_WF_FIN;
            cpit_pkg::ST_WF_FIN:  state_next = cpit_pkg::ST_EMIT;
            cpit_pkg::ST_EMIT:
                if (out_fire && out_last)
                    state_next = cpit_pkg::ST_IDLE;
            default:              state_next = cpit_pkg::ST_CLEAR;
        endcase
    end

    // outputs: handshakes and memory controls
    always_comb
    begin
        command.ready = (state_reg == cpit_pkg::ST_IDLE);
        result.valid  = (state_reg == cpit_pkg::ST_EMIT);
        result.manual_protect  = mp_reg;
        result.write_hit       = hit_reg;
        result.suspended_valid = sv_reg;
        result.suspended_block = sv_reg ? list_reg[k_reg[cpit_pkg::SLOT_BITS-1:0]] : '0;
        result.page_now_manual = pm_reg;
        result.overflow        = ov_reg;
        result.last            = out_last;

        pg_we    = 1'b0;
        pg_waddr = page_reg;
        pg_wdata = pg_rdata;
        pg_raddr = (state_reg == cpit_pkg::ST_WF_RD) ? wf_page_reg : page_reg;
        sl_we    = 1'b0;
        sl_wdata = sl_rdata;
        bk_we    = 1'b0;
        bk_waddr = ub_id_reg;
        bk_wdata = '0;
        bk_raddr = ub_id_reg;

        case (state_reg)
            cpit_pkg::ST_CLEAR:
            begin
                pg_we    = 1'b1;
                pg_waddr = clr_reg;
                pg_wdata = '0;
                bk_we    = 1'b1;
                bk_waddr = clr_reg[cpit_pkg::BLOCK_BITS-1:0];
            end
            cpit_pkg::ST_UP_WR:
                if (!pg_rdata.manual && scan.match_hit)
                begin
                    pg_we = 1'b1;
                    pg_wdata.valid[scan.match_idx] = 1'b0;
                end
            cpit_pkg::ST_UB_DONE:
                bk_we = ub_was_reg;
            cpit_pkg::ST_RG_WR:
                if (!pg_rdata.manual && ram_reg && scan.free_hit)
                begin
                    pg_we = 1'b1;
                    pg_wdata.valid[scan.free_idx] = 1'b1;
                    sl_we = 1'b1;
                    sl_wdata[scan.free_idx] = bid_reg;
                end
            cpit_pkg::ST_RG_DONE:
            begin
                bk_we    = 1'b1;
                bk_waddr = bid_reg;
                bk_wdata = '{registered: 1'b1, first_page: first_reg,
                             last_page: last_reg, in_ram: ram_reg};
            end
            cpit_pkg::ST_WF_FIN:
            begin
                pg_we    = 1'b1;
                pg_waddr = wf_page_reg;
                pg_wdata = '{manual: man_new, count: cnt_inc, valid: '0};
            end
            default: ;
        endcase
    end

    // datapath register updates
    always_comb
    begin
        clr_next     = clr_reg;
        cmd_next     = cmd_reg;
        bid_next     = bid_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        ram_next     = ram_reg;
        ub_id_next   = ub_id_reg;
        ub_last_next = ub_last_reg;
        ub_was_next  = ub_was_reg;
        page_next    = page_reg;
        wf_page_next = wf_page_reg;
        wf_man_next  = wf_man_reg;
        wf_cnt_next  = wf_cnt_reg;
        list_next    = list_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        mp_next      = mp_reg;
        ov_next      = ov_reg;
        hit_next     = hit_reg;
        pm_next      = pm_reg;
        sv_next      = sv_reg;

        case (state_reg)
            cpit_pkg::ST_CLEAR:
                clr_next = clr_reg + cpit_pkg::PAGE_BITS'(1);
            cpit_pkg::ST_IDLE:
                if (in_fire)
                begin
                    cmd_next     = command.cmd;
                    bid_next     = command.block_id;
                    ub_id_next   = command.block_id;
                    first_next   = command.start_address[cpit_pkg::OFFSET_BITS +:
                                                         cpit_pkg::PAGE_BITS];
                    last_next    = command.end_address[cpit_pkg::OFFSET_BITS +:
                                                       cpit_pkg::PAGE_BITS];
                    ram_next     = (command.start_address[cpit_pkg::REGION_LSB +: 3] ==
                                    cpit_pkg::REGION_RAM);
                    wf_page_next = command.write_offset[cpit_pkg::OFFSET_BITS +:
                                                        cpit_pkg::PAGE_BITS];
                    mp_next  = 1'b0;
                    ov_next  = 1'b0;
                    hit_next = 1'b0;
                    pm_next  = 1'b0;
                    sv_next  = 1'b0;
                    k_next   = '0;
                end
            cpit_pkg::ST_UB_CHK:
            begin
                ub_was_next  = bk_rdata.registered;
                page_next    = bk_rdata.first_page;
                ub_last_next = bk_rdata.last_page;
            end
            cpit_pkg::ST_UP_WR:
                page_next = page_reg + cpit_pkg::PAGE_BITS'(1);
            cpit_pkg::ST_UB_DONE:
                page_next = first_reg;
            cpit_pkg::ST_RG_WR:
            begin
                page_next = page_reg + cpit_pkg::PAGE_BITS'(1);
                if (pg_rdata.manual)
                    mp_next = 1'b1;
                else if (ram_reg && !scan.free_hit)
                    ov_next = 1'b1;
            end
            cpit_pkg::ST_WF_CHK:
            begin
                pm_next     = pg_rdata.manual;
                wf_man_next = pg_rdata.manual;
                wf_cnt_next = pg_rdata.count;
                list_next   = compact;
                n_next      = compact_n;
                k_next      = '0;
            end
            cpit_pkg::ST_WF_NEXT:
                if (k_reg < n_reg)
                begin
                    ub_id_next = list_reg[k_reg[cpit_pkg::SLOT_BITS-1:0]];
                    k_next     = k_reg + cpit_pkg::CNT_BITS'(1);
                end
            cpit_pkg::ST_WF_FIN:
            begin
                hit_next = 1'b1;
                pm_next  = man_new;
                sv_next  = 1'b1;
                k_next   = '0;
            end
            cpit_pkg::ST_EMIT:
                if (out_fire && !out_last)
                    k_next = k_reg + cpit_pkg::CNT_BITS'(1);
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpit_pkg::ST_CLEAR;
            clr_reg   <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
            sv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            sv_reg    <= sv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        bid_reg     <= bid_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        ram_reg     <= ram_next;
        ub_id_reg   <= ub_id_next;
        ub_last_reg <= ub_last_next;
        ub_was_reg  <= ub_was_next;
        page_reg    <= page_next;
        wf_page_reg <= wf_page_next;
        wf_man_reg  <= wf_man_next;
        wf_cnt_reg  <= wf_cnt_next;
        list_reg    <= list_next;
        mp_reg      <= mp_next;
        ov_reg      <= ov_next;
        hit_reg     <= hit_next;
        pm_reg      <= pm_next;
    end

endmodule

FILE: src/code_page_invalidation_tracker.sv
// Code page invalidation tracker, top level: limit register and sequencer.
// Depends on cpit_pkg, cpit_if, cpit_seq.
//
// command carries register, unregister and write-fault transactions; result
// returns one or more transactions per command, the final one marked by last.
// cfg_we/cfg_wdata load the invalidation limit (reset value 20).
// The block takes one command at a time: ready is high only when idle.
// A register first walks the pages of any earlier registration of the block
// to remove it, then the pages of its new span; an unregister walks only the
// earlier registration. A write fault on a page with listed blocks removes
// each of them the same way, then returns one result per block; on a page
// with no listed block, or outside RAM, it returns a single result.
// Each page step is a read then a write of the page memory. After reset a
// clearing pass zeroes the page and block tables; no command is taken
// meanwhile, configuration writes are.
// A stalled receiver holds the current result; nothing is lost.
module code_page_invalidation_tracker (
    input  logic       clk,
    input  logic       rst_n,
    cpit_cmd_if.sink   command,
    cpit_res_if.source result,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic [7:0] limit_reg, limit_next;

    // invalidation limit register
    assign limit_next = cfg_we ? cfg_wdata : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= cpit_pkg::LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    cpit_seq u_seq (
        .clk(clk),
        .rst_n(rst_n),
        .limit(limit_reg),
        .command(command),
        .result(result)
    );

endmodule

FILE: src/cpit_checker.sv
// Port-level checker for the tracker, bound to the top level.
// Depends on code_page_invalidation_tracker_macros.svh.
`include "code_page_invalidation_tracker_macros.svh"

module cpit_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_write_hit,
    input logic       out_suspended_valid,
    input logic [9:0] out_block,
    input logic       out_last
);

    // a stalled result transaction holds
    `CPIT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_block))
    // never takes a command while a result is pending
    `CPIT_ASSERT_NOW(a_excl, in_ready, !out_valid)
    // the block is busy in the cycle after it takes a command
    `CPIT_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)
    // a suspended block only comes with a write hit
    `CPIT_ASSERT_NOW(a_susp, out_valid && out_suspended_valid, out_write_hit)
    // results of one command follow back to back
    `CPIT_ASSERT_NEXT(a_burst, out_valid && out_ready && !out_last, out_valid)

endmodule

bind code_page_invalidation_tracker cpit_checker u_cpit_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(command.valid),
    .in_ready(command.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .out_write_hit(result.write_hit),
    .out_suspended_valid(result.suspended_valid),
    .out_block(result.suspended_block),
    .out_last(result.last)
);
